// ----- hdl/cmds_pkg.sv -----
// Package: constants, codes and control types of the circular diversity selector
`timescale 1ns / 1ps
package cmds_pkg;
  localparam int MAX_TAXA   = 32;
  localparam int MAX_SELECT = 16;
  localparam int VALUE_BITS = 32;
  localparam int POS_W      = $clog2(MAX_TAXA);
  localparam int SEL_W      = $clog2(MAX_SELECT);
  localparam int SCORE_W    = 40;
  localparam int PTR_W      = POS_W + 1;
  localparam int CNT_W      = SEL_W + 1;
  localparam int LAY_W      = SEL_W + 1;
  localparam int NCNT_W     = POS_W + 1;
  localparam int KCFG_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int REQ_W      = 2;
  localparam int TAXON_W    = 5;
  localparam int PAIR_DEPTH = MAX_TAXA * MAX_TAXA;
  localparam int LAYER_DEPTH = 2 * MAX_TAXA * MAX_TAXA;
  localparam int BP_DEPTH   = (MAX_SELECT - 2) * MAX_TAXA * MAX_TAXA;
  localparam logic [PTR_W-1:0] PTR_UNSET = '1;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [NCNT_W-1:0] TAXA_RESET = NCNT_W'(MAX_TAXA);
  localparam logic [KCFG_W-1:0] TARGET_RESET = KCFG_W'(2);

  typedef enum logic [REQ_W-1:0] {
    REQ_PAIR  = 2'd0,
    REQ_TAXON = 2'd1,
    REQ_RUN   = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAXA_COUNT  = 2'd0,
    REG_TARGET_SIZE = 2'd1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_FSET, ST_LU, ST_LV, ST_LRD, ST_LACC, ST_LWR,
    ST_FU, ST_FV, ST_FRD, ST_FACC, ST_TINIT, ST_TCHK, ST_TRD, ST_TSTEP,
    ST_EOUT, ST_FAIL
  } state_t;

  typedef struct packed {
    logic idle;
    logic run_init;
    logic lay_next;
    logic f_start;
    logic u_next;
    logic v_init;
    logic acc;
    logic wr;
    logic t_init;
    logic t_step;
    logic t_end;
    logic e_load;
    logic fail_load;
  } cmd_t;

  typedef struct packed {
    logic run_req;
    logic bad_k;
    logic k_two;
    logic u_ok;
    logic v_ok;
    logic s_more;
    logic s_last;
    logic lay_last;
    logic found;
    logic t_done;
    logic t_gap;
    logic t_bad;
    logic out_free;
    logic e_last;
  } sts_t;
endpackage

// ----- hdl/cmds_in_if.sv -----
// Interface: request item channel
`timescale 1ns / 1ps
interface cmds_in_if;
  import cmds_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [POS_W-1:0]      row_pos;
  logic [POS_W-1:0]      col_pos;
  logic [VALUE_BITS-1:0] pair_value;
  logic [TAXON_W-1:0]    taxon_id;
  modport source (output valid, req_type, row_pos, col_pos, pair_value, taxon_id,
                  input ready);
  modport sink (input valid, req_type, row_pos, col_pos, pair_value, taxon_id,
                output ready);
endinterface

// ----- hdl/cmds_out_if.sv -----
// Interface: result item channel
`timescale 1ns / 1ps
interface cmds_out_if;
  import cmds_pkg::*;
  logic               valid;
  logic               ready;
  logic [TAXON_W-1:0] member_taxon;
  logic               last_member;
  logic               failed;
  modport source (output valid, member_taxon, last_member, failed, input ready);
  modport sink (input valid, member_taxon, last_member, failed, output ready);
endinterface

// ----- hdl/cmds_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps
module cmds_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/cmds_dp.sv -----
// Datapath: tables, loop counters, saturating accumulate, trace-back and result register
`timescale 1ns / 1ps
module cmds_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  cmds_in_if.sink                            in_ch,
  cmds_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [cmds_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [cmds_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  cmds_pkg::cmd_t                     cmd,
  output cmds_pkg::sts_t                     sts
);
  import cmds_pkg::*;

  localparam int SUM_W = SCORE_W + 1;
  localparam int EXT_W = NCNT_W + 1;

  logic [NCNT_W-1:0]  taxa_count_r;
  logic [KCFG_W-1:0]  target_size_r;
  logic [TAXON_W-1:0] taxa_r [MAX_TAXA];
  logic [POS_W-1:0]   mem_r [MAX_SELECT];
  logic [LAY_W-1:0]   lay_r;
  logic [NCNT_W-1:0]  u_r, v_r, s_r;
  logic [POS_W-1:0]   bu_r, bv_r;
  logic [SCORE_W-1:0] mx_r, best_r;
  logic [PTR_W-1:0]   arg_r;
  logic               found_r, fin_r;
  logic [CNT_W-1:0]   cnt_r, em_r;
  logic               out_valid_r;
  logic [TAXON_W-1:0] out_member_r;
  logic               out_last_r, out_failed_r;

  logic               in_fire;
  logic [NCNT_W-1:0]  n;
  logic [KCFG_W-1:0]  k;
  logic [SCORE_W-1:0] layer_rd, prev_val, t_val;
  logic [VALUE_BITS-1:0] pa_rd, pb_rd;
  logic [PTR_W-1:0]   bp_rd;
  logic [SUM_W-1:0]   sum;
  logic               mask_zero;
  logic [EXT_W-1:0]   u_ext, s_ext, v_ext, lay_ext, n_ext, bu_ext;
  logic [SEL_W-2+1:0] lay_m3;
  logic               pair_we;
  logic [$clog2(PAIR_DEPTH)-1:0]  pair_wa, pa_ra, pb_ra;
  logic [$clog2(LAYER_DEPTH)-1:0] lay_wa, lay_ra;
  logic [$clog2(BP_DEPTH)-1:0]    bp_wa, bp_ra;

  assign in_fire  = in_ch.valid && cmd.idle;
  assign in_ch.ready = cmd.idle;
  assign n = (taxa_count_r > NCNT_W'(MAX_TAXA)) ? NCNT_W'(MAX_TAXA) : taxa_count_r;
  assign k = target_size_r;

  assign u_ext   = EXT_W'(u_r);
  assign s_ext   = EXT_W'(s_r);
  assign v_ext   = EXT_W'(v_r);
  assign lay_ext = EXT_W'(lay_r);
  assign n_ext   = EXT_W'(n);
  assign bu_ext  = EXT_W'(bu_r);
  assign lay_m3  = SEL_W'(lay_r - LAY_W'(3));

  assign pair_we = in_fire && (in_ch.req_type == REQ_PAIR);
  assign pair_wa = {in_ch.row_pos, in_ch.col_pos};
  assign pa_ra   = fin_r ? {u_r[POS_W-1:0], v_r[POS_W-1:0]}
                         : {s_r[POS_W-1:0], v_r[POS_W-1:0]};
  assign pb_ra   = fin_r ? {u_r[POS_W-1:0], v_r[POS_W-1:0]}
                         : {u_r[POS_W-1:0], s_r[POS_W-1:0]};
  assign lay_wa  = {lay_r[0], u_r[POS_W-1:0], v_r[POS_W-1:0]};
  assign lay_ra  = fin_r ? {lay_r[0], u_r[POS_W-1:0], v_r[POS_W-1:0]}
                         : {~lay_r[0], u_r[POS_W-1:0], s_r[POS_W-1:0]};
  assign bp_wa   = {lay_m3, u_r[POS_W-1:0], v_r[POS_W-1:0]};
  assign bp_ra   = {lay_m3, bu_r, v_r[POS_W-1:0]};

  cmds_ram #(.W(VALUE_BITS), .D(PAIR_DEPTH)) u_pair_a (
    .clk(clk), .we(pair_we), .waddr(pair_wa), .wdata(in_ch.pair_value),
    .raddr(pa_ra), .rdata(pa_rd));

  cmds_ram #(.W(VALUE_BITS), .D(PAIR_DEPTH)) u_pair_b (
    .clk(clk), .we(pair_we), .waddr(pair_wa), .wdata(in_ch.pair_value),
    .raddr(pb_ra), .rdata(pb_rd));

  cmds_ram #(.W(SCORE_W), .D(LAYER_DEPTH)) u_layer (
    .clk(clk), .we(cmd.wr), .waddr(lay_wa), .wdata(mx_r),
    .raddr(lay_ra), .rdata(layer_rd));

  cmds_ram #(.W(PTR_W), .D(BP_DEPTH)) u_bp (
    .clk(clk), .we(cmd.wr), .waddr(bp_wa), .wdata(arg_r),
    .raddr(bp_ra), .rdata(bp_rd));

  // entries of the previous layer below its start diagonal read as zero
  assign mask_zero = (lay_r > LAY_W'(3)) && (s_ext < u_ext + lay_ext - EXT_W'(2));

  always_comb begin
    if (fin_r) begin
      prev_val = (lay_r == LAY_W'(2)) ? SCORE_W'(pb_rd) : layer_rd;
    end else if (lay_r == LAY_W'(3)) begin
      prev_val = SCORE_W'(pb_rd);
    end else begin
      prev_val = mask_zero ? '0 : layer_rd;
    end
  end

  assign sum   = SUM_W'(prev_val) + SUM_W'(pa_rd);
  assign t_val = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];

  assign sts.run_req  = in_fire && (in_ch.req_type == REQ_RUN);
  assign sts.bad_k    = (k < KCFG_W'(2)) || (k > KCFG_W'(MAX_SELECT));
  assign sts.k_two    = (k == KCFG_W'(2));
  assign sts.u_ok     = (u_ext + lay_ext) <= (n_ext + EXT_W'(1));
  assign sts.v_ok     = v_r < n;
  assign sts.s_more   = s_r < v_r;
  assign sts.s_last   = (s_ext + EXT_W'(1)) >= v_ext;
  assign sts.lay_last = lay_r >= LAY_W'(k);
  assign sts.found    = found_r;
  assign sts.t_done   = lay_r <= LAY_W'(2);
  assign sts.t_gap    = v_ext < (bu_ext + lay_ext - EXT_W'(1));
  assign sts.t_bad    = bp_rd >= PTR_W'(MAX_TAXA);
  assign sts.out_free = !out_valid_r || out_ch.ready;
  assign sts.e_last   = (em_r + CNT_W'(1)) == cnt_r;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.member_taxon = out_member_r;
  assign out_ch.last_member  = out_last_r;
  assign out_ch.failed       = out_failed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taxa_count_r  <= TAXA_RESET;
      target_size_r <= TARGET_RESET;
      found_r       <= 1'b0;
      fin_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_idx == REG_TAXA_COUNT)) begin
        taxa_count_r <= cfg_data[NCNT_W-1:0];
      end
      if (cfg_we && (cfg_idx == REG_TARGET_SIZE)) begin
        target_size_r <= cfg_data[KCFG_W-1:0];
      end
      if (cmd.run_init) begin
        found_r <= 1'b0;
        fin_r   <= 1'b0;
      end
      if (cmd.f_start) begin
        fin_r <= 1'b1;
      end
      if (cmd.acc && fin_r && (t_val > best_r)) begin
        found_r <= 1'b1;
      end
      if (cmd.e_load || cmd.fail_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.req_type == REQ_TAXON)) begin
      taxa_r[in_ch.row_pos] <= in_ch.taxon_id;
    end
    if (cmd.run_init) begin
      lay_r  <= LAY_W'(3);
      u_r    <= '0;
      best_r <= '0;
    end
    if (cmd.lay_next) begin
      lay_r <= lay_r + LAY_W'(1);
      u_r   <= '0;
    end
    if (cmd.f_start) begin
      lay_r <= LAY_W'(k);
      u_r   <= '0;
    end
    if (cmd.u_next) begin
      u_r <= u_r + NCNT_W'(1);
    end
    if (cmd.v_init) begin
      v_r   <= NCNT_W'(u_ext + lay_ext - EXT_W'(1));
      s_r   <= u_r + NCNT_W'(1);
      mx_r  <= '0;
      arg_r <= PTR_UNSET;
    end
    if (cmd.acc) begin
      if (fin_r) begin
        if (t_val > best_r) begin
          best_r <= t_val;
          bu_r   <= u_r[POS_W-1:0];
          bv_r   <= v_r[POS_W-1:0];
        end
        v_r <= v_r + NCNT_W'(1);
      end else begin
        if (t_val > mx_r) begin
          mx_r  <= t_val;
          arg_r <= PTR_W'(s_r);
        end
        s_r <= s_r + NCNT_W'(1);
      end
    end
    if (cmd.wr) begin
      v_r   <= v_r + NCNT_W'(1);
      s_r   <= u_r + NCNT_W'(1);
      mx_r  <= '0;
      arg_r <= PTR_UNSET;
    end
    if (cmd.t_init) begin
      mem_r[0] <= bv_r;
      cnt_r    <= CNT_W'(1);
      v_r      <= NCNT_W'(bv_r);
      lay_r    <= LAY_W'(k);
    end
    if (cmd.t_step) begin
      mem_r[cnt_r[SEL_W-1:0]] <= bp_rd[POS_W-1:0];
      cnt_r <= cnt_r + CNT_W'(1);
      v_r   <= NCNT_W'(bp_rd[POS_W-1:0]);
      lay_r <= lay_r - LAY_W'(1);
    end
    if (cmd.t_end) begin
      mem_r[cnt_r[SEL_W-1:0]] <= bu_r;
      cnt_r <= cnt_r + CNT_W'(1);
      em_r  <= '0;
    end
    if (cmd.e_load) begin
      out_member_r <= taxa_r[mem_r[em_r[SEL_W-1:0]]];
      out_last_r   <= sts.e_last;
      out_failed_r <= 1'b0;
      em_r         <= em_r + CNT_W'(1);
    end
    if (cmd.fail_load) begin
      out_member_r <= '0;
      out_last_r   <= 1'b1;
      out_failed_r <= 1'b1;
    end
  end
endmodule

// ----- hdl/cmds_ctrl.sv -----
// Controller: run sequencing state machine for layers, end search, trace-back and emit
`timescale 1ns / 1ps
module cmds_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  cmds_pkg::sts_t  sts,
  output cmds_pkg::cmd_t  cmd
);
  import cmds_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (sts.run_req) state_nxt = ST_START;
      ST_START: begin
        if (sts.bad_k) state_nxt = ST_FAIL;
        else if (sts.k_two) state_nxt = ST_FSET;
        else state_nxt = ST_LU;
      end
      ST_FSET:  state_nxt = ST_FU;
      ST_LU: begin
        if (sts.u_ok) state_nxt = ST_LV;
        else if (sts.lay_last) state_nxt = ST_FSET;
      end
      ST_LV: begin
        if (!sts.v_ok) state_nxt = ST_LU;
        else if (sts.s_more) state_nxt = ST_LRD;
        else state_nxt = ST_LWR;
      end
      ST_LRD:   state_nxt = ST_LACC;
      ST_LACC:  state_nxt = sts.s_last ? ST_LWR : ST_LRD;
      ST_LWR:   state_nxt = ST_LV;
      ST_FU: begin
        if (sts.u_ok) state_nxt = ST_FV;
        else state_nxt = sts.found ? ST_TINIT : ST_FAIL;
      end
      ST_FV:    state_nxt = sts.v_ok ? ST_FRD : ST_FU;
      ST_FRD:   state_nxt = ST_FACC;
      ST_FACC:  state_nxt = ST_FV;
      ST_TINIT: state_nxt = ST_TCHK;
      ST_TCHK: begin
        if (sts.t_done) state_nxt = ST_EOUT;
        else if (sts.t_gap) state_nxt = ST_FAIL;
        else state_nxt = ST_TRD;
      end
      ST_TRD:   state_nxt = ST_TSTEP;
      ST_TSTEP: state_nxt = sts.t_bad ? ST_FAIL : ST_TCHK;
      ST_EOUT:  if (sts.out_free && sts.e_last) state_nxt = ST_IDLE;
      ST_FAIL:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:  cmd.idle = 1'b1;
      ST_START: cmd.run_init = 1'b1;
      ST_FSET:  cmd.f_start = 1'b1;
      ST_LU: begin
        if (sts.u_ok) cmd.v_init = 1'b1;
        else if (!sts.lay_last) cmd.lay_next = 1'b1;
      end
      ST_LV:    if (!sts.v_ok) cmd.u_next = 1'b1;
      ST_LACC:  cmd.acc = 1'b1;
      ST_LWR:   cmd.wr = 1'b1;
      ST_FU:    if (sts.u_ok) cmd.v_init = 1'b1;
      ST_FV:    if (!sts.v_ok) cmd.u_next = 1'b1;
      ST_FACC:  cmd.acc = 1'b1;
      ST_TINIT: cmd.t_init = 1'b1;
      ST_TCHK:  if (sts.t_done) cmd.t_end = 1'b1;
      ST_TSTEP: if (!sts.t_bad) cmd.t_step = 1'b1;
      ST_EOUT:  if (sts.out_free) cmd.e_load = 1'b1;
      ST_FAIL:  if (sts.out_free) cmd.fail_load = 1'b1;
      default:  cmd = '0;
    endcase
  end
endmodule

// ----- hdl/circular_max_diversity_select_top.sv -----
// Top level of the circular maximum-diversity selector
// Loads (pair value, taxon) are taken one item at a time, only while idle.
// A run takes inner split steps one at a time, a read state then an accumulate state each,
// set by the one read port of the score layer memory and the single accumulate unit; a
// trace-back step runs check, read, step; members go out one per cycle while out_ch is ready.
// Reset (rst_n, synchronous, low) returns taxa_count to 32, target_size to 2 and goes idle;
// no clearing pass: table contents are left as they are.
`timescale 1ns / 1ps
module circular_max_diversity_select_top (
  input  logic                              clk,
  input  logic                              rst_n,
  cmds_in_if.sink                           in_ch,
  cmds_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [cmds_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [cmds_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cmds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cmds_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .sts(sts), .cmd(cmd));

  cmds_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts));
endmodule
